// ----- hdl/ila_pkg.sv -----
// Shared types and codes for the indexed list block.
package ila_pkg;

  // Most results a single dump request may produce
  localparam int MAX_RESULTS = 16;

  // Request kinds
  localparam logic [2:0] KIND_APPEND    = 3'd0;
  localparam logic [2:0] KIND_INSERT    = 3'd1;
  localparam logic [2:0] KIND_REMOVE    = 3'd2;
  localparam logic [2:0] KIND_REM_FIRST = 3'd3;
  localparam logic [2:0] KIND_REM_LAST  = 3'd4;
  localparam logic [2:0] KIND_DUMP      = 3'd5;

  // Result status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_BOUNDS = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;

  // Command broadcast to every cell of the row
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_REMOVE,
    OP_ROTATE
  } cell_op_t;

  typedef struct packed {
    logic [2:0]         kind;
    logic [4:0]         position;
    logic signed [31:0] value;
  } in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [4:0]         count;
    logic signed [31:0] element;
    logic               last;
  } out_t;

endpackage

// ----- hdl/ila_cell.sv -----
// One storage cell of the list row: holds a word and shifts to or from its neighbors.
module ila_cell #(
  parameter int INDEX = 0,
  parameter int PW    = 5
) (
  input  logic                clk,
  input  ila_pkg::cell_op_t   op,
  input  logic [PW-1:0]       sel_pos,
  input  logic signed [31:0]  value,
  input  logic signed [31:0]  left_d,
  input  logic signed [31:0]  right_d,
  input  logic signed [31:0]  head_d,
  output logic signed [31:0]  q
);
  import ila_pkg::*;

  localparam logic [PW-1:0] IDX = PW'(INDEX);

  logic signed [31:0] q_r;
  logic signed [31:0] q_nxt;

  // insert: open a gap at sel_pos; remove: close it; rotate: left by one,
  // wrapping the head word into the tail cell at sel_pos
  always_comb begin
    q_nxt = q_r;
    unique case (op)
      OP_INSERT: begin
        if (IDX == sel_pos) q_nxt = value;
        else if (IDX > sel_pos) q_nxt = left_d;
      end
      OP_REMOVE: begin
        if (IDX >= sel_pos) q_nxt = right_d;
      end
      OP_ROTATE: begin
        if (IDX == sel_pos) q_nxt = head_d;
        else if (IDX < sel_pos) q_nxt = right_d;
      end
      default: q_nxt = q_r;
    endcase
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q = q_r;

endmodule

// ----- hdl/indexed_list_insert_remove.sv -----
// Top level of the indexed list: request decode, fill count, dump sequencer, cell row.
//
//  channel  ports                       transfer when
//  -------  --------------------------  --------------------------
//  request  start, busy, in_data        start high and busy low
//  result   out_strobe, out_data        out_strobe high (one cycle)
//
// Append, insert and the removes finish in the accept cycle; the result shows
// on the next cycle and a new request may be taken right away.
// A dump keeps busy high while the cell row rotates left once per cycle; the
// word in cell 0 is emitted each cycle for the first MAX_RESULTS rotations,
// and once every filled cell has rotated, the list is back in its original order.
// Reset clears the fill count and the sequencer; cell contents are not cleared.
// The receiver cannot stall: each result is valid for exactly one cycle.
module indexed_list_insert_remove #(
  parameter int CAPACITY = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  ila_pkg::in_t  in_data,
  output logic          out_strobe,
  output ila_pkg::out_t out_data
);
  import ila_pkg::*;

  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > 5) ? CW : 5;

  typedef enum logic {S_IDLE, S_DUMP} state_t;

  state_t          state_r;
  logic [CW-1:0]   fill_r;
  logic [CW-1:0]   fill_nxt;
  logic [CW-1:0]   dcnt_r;
  logic            out_strobe_r;
  out_t            out_r;

  logic            accept;
  cell_op_t        op;
  logic [CMPW-1:0] sel_pos_w;
  logic [CW-1:0]   sel_pos;
  logic [1:0]      res_status;
  logic            go_dump;

  logic [CMPW-1:0] fill_w;
  logic [CMPW-1:0] pos_w;
  logic [CMPW-1:0] dcnt_w;
  logic [CMPW-1:0] dump_n;
  logic            dump_emit;
  logic            dump_last;
  logic            dump_done;
  logic            is_full;

  logic signed [31:0] cell_q [CAPACITY];

  assign accept = start && (state_r == S_IDLE);
  assign busy   = (state_r != S_IDLE);

  assign fill_w  = CMPW'(fill_r);
  assign pos_w   = CMPW'(in_data.position);
  assign dcnt_w  = CMPW'(dcnt_r);
  assign is_full = (fill_w == CMPW'(CAPACITY));

  // dump bookkeeping: emit at most MAX_RESULTS words, rotate the full fill
  assign dump_n    = (fill_w > CMPW'(MAX_RESULTS)) ? CMPW'(MAX_RESULTS) : fill_w;
  assign dump_emit = (dcnt_w < CMPW'(MAX_RESULTS));
  assign dump_last = ((dcnt_w + CMPW'(1)) == dump_n);
  assign dump_done = ((dcnt_w + CMPW'(1)) == fill_w);

  // request decode into a row command and the next fill count
  always_comb begin
    op         = OP_HOLD;
    sel_pos_w  = '0;
    fill_nxt   = fill_r;
    res_status = ST_OK;
    go_dump    = 1'b0;
    if (state_r == S_DUMP) begin
      op        = OP_ROTATE;
      sel_pos_w = fill_w - CMPW'(1);
    end else if (accept) begin
      unique case (in_data.kind)
        KIND_APPEND: begin
          if (is_full) begin
            res_status = ST_FULL;
          end else begin
            op        = OP_INSERT;
            sel_pos_w = fill_w;
            fill_nxt  = fill_r + CW'(1);
          end
        end
        KIND_INSERT: begin
          if (pos_w > fill_w) begin
            res_status = ST_BOUNDS;
          end else if (is_full) begin
            res_status = ST_FULL;
          end else begin
            op        = OP_INSERT;
            sel_pos_w = pos_w;
            fill_nxt  = fill_r + CW'(1);
          end
        end
        KIND_REMOVE: begin
          if (pos_w >= fill_w) begin
            res_status = ST_BOUNDS;
          end else begin
            op        = OP_REMOVE;
            sel_pos_w = pos_w;
            fill_nxt  = fill_r - CW'(1);
          end
        end
        KIND_REM_FIRST: begin
          if (fill_r == '0) begin
            res_status = ST_BOUNDS;
          end else begin
            op       = OP_REMOVE;
            fill_nxt = fill_r - CW'(1);
          end
        end
        KIND_REM_LAST: begin
          if (fill_r == '0) begin
            res_status = ST_BOUNDS;
          end else begin
            op        = OP_REMOVE;
            sel_pos_w = fill_w - CMPW'(1);
            fill_nxt  = fill_r - CW'(1);
          end
        end
        KIND_DUMP: begin
          if (fill_r == '0) res_status = ST_BOUNDS;
          else go_dump = 1'b1;
        end
        default: res_status = ST_OK;
      endcase
    end
  end

  // only in-range positions reach the row, so truncation is safe
  assign sel_pos = CW'(sel_pos_w);

  // cell row
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [31:0] left_d;
    logic signed [31:0] right_d;
    if (i == 0) begin : g_first
      assign left_d = '0;
    end else begin : g_mid_l
      assign left_d = cell_q[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_d = '0;
    end else begin : g_mid_r
      assign right_d = cell_q[i+1];
    end
    ila_cell #(
      .INDEX (i),
      .PW    (CW)
    ) u_cell (
      .clk     (clk),
      .op      (op),
      .sel_pos (sel_pos),
      .value   (in_data.value),
      .left_d  (left_d),
      .right_d (right_d),
      .head_d  (cell_q[0]),
      .q       (cell_q[i])
    );
  end

  // sequencer state and registered result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      fill_r       <= '0;
      dcnt_r       <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      fill_r <= fill_nxt;
      unique case (state_r)
        S_IDLE: begin
          out_strobe_r <= accept && !go_dump;
          if (accept) begin
            if (go_dump) begin
              state_r <= S_DUMP;
              dcnt_r  <= '0;
            end else begin
              out_r.status    <= res_status;
              out_r.count     <= 5'(fill_nxt);
              out_r.element   <= '0;
              out_r.last      <= 1'b1;
            end
          end
        end
        S_DUMP: begin
          out_strobe_r  <= dump_emit;
          out_r.status  <= ST_OK;
          out_r.count   <= 5'(fill_r);
          out_r.element <= cell_q[0];
          out_r.last    <= dump_last;
          dcnt_r        <= dcnt_r + CW'(1);
          if (dump_done) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = out_r;

endmodule

// ----- hdl/ila_checker.sv -----
// Port-level checks for the indexed list, bound to the top level.
module ila_checker #(
  parameter int CAPACITY = 16
) (
  input logic          clk,
  input logic          rst_n,
  input logic          start,
  input logic          busy,
  input ila_pkg::in_t  in_data,
  input logic          out_strobe,
  input ila_pkg::out_t out_data
);
  import ila_pkg::*;

  // any request other than dump answers with one final result next cycle
  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_data.kind != KIND_DUMP) |=> (out_strobe && out_data.last))
    else $error("non-dump request did not give a final result next cycle");

  // a full report only comes from a list at capacity
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_data.status == ST_FULL) |-> (out_data.count == 5'(CAPACITY)))
    else $error("full status with count below capacity");

  // error results carry no element and end the request
  a_err_final: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_data.status != ST_OK) |-> (out_data.last && out_data.element == '0))
    else $error("error result not final or carries an element");

  // end of a dump coincides with its final result
  a_dump_end: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $fell(busy)) |-> (out_strobe && out_data.last))
    else $error("dump ended without a final result");

endmodule

bind indexed_list_insert_remove ila_checker #(
  .CAPACITY (CAPACITY)
) u_ila_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .in_data    (in_data),
  .out_strobe (out_strobe),
  .out_data   (out_data)
);

// ----- bench/tb_indexed_list_insert_remove.sv -----
// Self-checking testbench for the indexed list: directed table, random request episodes.
module tb_indexed_list_insert_remove;
  import ila_pkg::*;

  localparam int LIST_CAPACITY = 16;
  localparam int RANDOM_TARGET = 230;
  localparam int STALL_LIMIT   = 500;
  localparam int DRAIN_CYCLES  = 20;
  // Kinds outside the decoded set
  localparam logic [2:0] KIND_UNUSED_6 = 3'd6;
  localparam logic [2:0] KIND_UNUSED_7 = 3'd7;

  typedef struct {
    in_t  req;
    bit   typed;
    out_t want;
  } list_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_t  in_data = '0;
  logic out_strobe;
  out_t out_data;

  // Shadow copy of the list contents, and results still owed by the block
  logic signed [31:0] shadow_words[$];
  out_t               step_results[$];
  out_t               pending_results[$];
  list_row_t          directed_rows[$];
  int                 requests_sent = 0;
  int                 mismatch_count = 0;
  int                 stall_cycles = 0;

  indexed_list_insert_remove #(
    .CAPACITY(LIST_CAPACITY)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_data(in_data),
    .out_strobe(out_strobe),
    .out_data(out_data)
  );

  always #5 clk = ~clk;

  function automatic in_t make_req(input logic [2:0] k, input logic [4:0] p,
                                   input logic [31:0] v);
    in_t r;
    r.kind = k;
    r.position = p;
    r.value = v;
    return r;
  endfunction

  // Random words half the time, the other half sign and magnitude extremes
  function automatic logic [31:0] random_word();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic add_row(input logic [2:0] k, input logic [4:0] p, input logic [31:0] v,
                         input bit typed, input logic [1:0] st, input logic [4:0] cnt);
    list_row_t row;
    row.req = make_req(k, p, v);
    row.typed = typed;
    row.want.status = st;
    row.want.count = cnt;
    row.want.element = '0;
    row.want.last = 1'b1;
    directed_rows.push_back(row);
  endtask

  // Apply one request to the shadow list and collect the results it causes
  task automatic predict_list_op(input in_t req);
    logic [1:0] st;
    int n;
    out_t r;
    step_results.delete();
    st = ST_OK;
    case (req.kind)
      KIND_APPEND: begin
        if (shadow_words.size() >= LIST_CAPACITY) st = ST_FULL;
        else shadow_words.push_back(req.value);
      end
      KIND_INSERT: begin
        // bounds takes priority over full
        if (req.position > shadow_words.size()) st = ST_BOUNDS;
        else if (shadow_words.size() >= LIST_CAPACITY) st = ST_FULL;
        else shadow_words.insert(req.position, req.value);
      end
      KIND_REMOVE: begin
        if (req.position >= shadow_words.size()) st = ST_BOUNDS;
        else shadow_words.delete(req.position);
      end
      KIND_REM_FIRST: begin
        if (shadow_words.size() == 0) st = ST_BOUNDS;
        else shadow_words.delete(0);
      end
      KIND_REM_LAST: begin
        if (shadow_words.size() == 0) st = ST_BOUNDS;
        else shadow_words.delete(shadow_words.size() - 1);
      end
      KIND_DUMP: begin
        n = (shadow_words.size() > MAX_RESULTS) ? MAX_RESULTS : shadow_words.size();
        if (n == 0) st = ST_BOUNDS;
        for (int i = 0; i < n; i++) begin
          r.status = ST_OK;
          r.count = 5'(shadow_words.size());
          r.element = shadow_words[i];
          r.last = (i == n - 1);
          step_results.push_back(r);
        end
      end
      default: ;
    endcase
    // every request but a non-empty dump gives one closing result
    if (step_results.size() == 0) begin
      r.status = st;
      r.count = 5'(shadow_words.size());
      r.element = '0;
      r.last = 1'b1;
      step_results.push_back(r);
    end
  endtask

  // Entered and left just after a falling edge
  task automatic send_request(input in_t req, input bit typed, input out_t want);
    // random gaps, except over a long burst in the middle of the run
    if (!(requests_sent >= 110 && requests_sent < 170) && $urandom_range(0, 99) < 20) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    start <= 1'b1;
    in_data <= req;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_list_op(req);
    if (typed) pending_results.push_back(want);
    else foreach (step_results[i]) pending_results.push_back(step_results[i]);
    requests_sent++;
    @(negedge clk);
  endtask

  task automatic send_op(input logic [2:0] k, input logic [4:0] p, input logic [31:0] v);
    send_request(make_req(k, p, v), 1'b0, '0);
  endtask

  task automatic wait_for_drain();
    start <= 1'b0;
    @(negedge clk);
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // Result checker and watchdog
  always @(posedge clk) begin
    out_t want;
    if (rst_n) begin
      if ((start && !busy) || out_strobe) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end else if (out_strobe) begin
        if (pending_results.size() == 0) begin
          $error("result transfer with nothing expected: status %0d count %0d element %0d",
                 out_data.status, out_data.count, out_data.element);
          mismatch_count++;
        end else begin
          want = pending_results.pop_front();
          if (out_data.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, out_data.status);
            mismatch_count++;
          end
          if (out_data.count !== want.count) begin
            $error("count: expected %0d, actual %0d", want.count, out_data.count);
            mismatch_count++;
          end
          if (out_data.element !== want.element) begin
            $error("element: expected %0d, actual %0d", want.element, out_data.element);
            mismatch_count++;
          end
          if (out_data.last !== want.last) begin
            $error("last: expected %0d, actual %0d", want.last, out_data.last);
            mismatch_count++;
          end
        end
      end
    end
  end

  // Stimulus
  initial begin
    int sz;
    int pick;
    int steps;

    // directed table: empty-list errors, extremes, every kind
    add_row(KIND_DUMP,      5'd0,  32'h0000_0000, 1'b1, ST_BOUNDS, 5'd0);
    add_row(KIND_REM_FIRST, 5'd0,  32'hFFFF_FFFF, 1'b1, ST_BOUNDS, 5'd0);
    add_row(KIND_REM_LAST,  5'd31, 32'h0000_0000, 1'b1, ST_BOUNDS, 5'd0);
    add_row(KIND_REMOVE,    5'd31, 32'h0000_0000, 1'b1, ST_BOUNDS, 5'd0);
    add_row(KIND_REMOVE,    5'd0,  32'h0000_0000, 1'b1, ST_BOUNDS, 5'd0);
    add_row(KIND_INSERT,    5'd1,  32'h1234_5678, 1'b1, ST_BOUNDS, 5'd0);
    add_row(KIND_INSERT,    5'd0,  32'h8000_0000, 1'b1, ST_OK,     5'd1);
    add_row(KIND_APPEND,    5'd0,  32'h7FFF_FFFF, 1'b1, ST_OK,     5'd2);
    add_row(KIND_INSERT,    5'd2,  32'hFFFF_FFFF, 1'b1, ST_OK,     5'd3);
    add_row(KIND_INSERT,    5'd1,  32'h0000_0000, 1'b1, ST_OK,     5'd4);
    add_row(KIND_APPEND,    5'd31, 32'hA5A5_5A5A, 1'b1, ST_OK,     5'd5);
    add_row(KIND_DUMP,      5'd0,  32'h0000_0000, 1'b0, ST_OK,     5'd0);
    add_row(KIND_REMOVE,    5'd5,  32'h0000_0000, 1'b1, ST_BOUNDS, 5'd5);
    add_row(KIND_INSERT,    5'd6,  32'h0000_0001, 1'b1, ST_BOUNDS, 5'd5);
    add_row(KIND_REMOVE,    5'd1,  32'h0000_0000, 1'b1, ST_OK,     5'd4);
    add_row(KIND_REM_FIRST, 5'd0,  32'h0000_0000, 1'b1, ST_OK,     5'd3);
    add_row(KIND_REM_LAST,  5'd0,  32'h0000_0000, 1'b1, ST_OK,     5'd2);
    add_row(KIND_UNUSED_6,  5'd0,  32'h0000_0000, 1'b1, ST_OK,     5'd2);
    add_row(KIND_UNUSED_7,  5'd31, 32'hFFFF_FFFF, 1'b1, ST_OK,     5'd2);
    add_row(KIND_DUMP,      5'd31, 32'hFFFF_FFFF, 1'b0, ST_OK,     5'd0);

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
    wait_for_drain();

    // random episodes: fill to capacity, drain to empty, mixed traffic, full pause
    while (requests_sent < RANDOM_TARGET) begin
      pick = $urandom_range(0, 9);
      if (pick < 3) begin
        while (shadow_words.size() < LIST_CAPACITY) begin
          if ($urandom_range(0, 1)) send_op(KIND_APPEND, 5'($urandom), random_word());
          else send_op(KIND_INSERT, 5'($urandom_range(0, shadow_words.size())),
                       random_word());
        end
        // full list: in-range adds report full, a position past the end reports bounds
        repeat ($urandom_range(1, 2))
          send_op($urandom_range(0, 1) ? KIND_APPEND : KIND_INSERT,
                  5'($urandom_range(0, LIST_CAPACITY)), random_word());
        send_op(KIND_INSERT, 5'($urandom_range(LIST_CAPACITY + 1, 31)), random_word());
        send_op(KIND_DUMP, 5'($urandom), $urandom);
      end else if (pick < 5) begin
        // one extra remove lands on the empty list
        steps = shadow_words.size() + 1;
        repeat (steps) begin
          sz = shadow_words.size();
          case ($urandom_range(0, 2))
            0: send_op(KIND_REMOVE, 5'($urandom_range(0, (sz > 0) ? sz - 1 : 31)), $urandom);
            1: send_op(KIND_REM_FIRST, 5'($urandom), $urandom);
            default: send_op(KIND_REM_LAST, 5'($urandom), $urandom);
          endcase
        end
        send_op(KIND_DUMP, 5'($urandom), $urandom);
      end else if (pick < 9) begin
        repeat (12) begin
          sz = shadow_words.size();
          pick = $urandom_range(0, 99);
          if (pick < 25) send_op(KIND_APPEND, 5'($urandom), random_word());
          else if (pick < 45) send_op(KIND_INSERT, 5'($urandom_range(0, sz)), random_word());
          else if (pick < 62)
            send_op(KIND_REMOVE, 5'($urandom_range(0, (sz > 0) ? sz - 1 : 31)),
                    random_word());
          else if (pick < 70) send_op(KIND_REM_FIRST, 5'($urandom), random_word());
          else if (pick < 78) send_op(KIND_REM_LAST, 5'($urandom), random_word());
          else if (pick < 86) send_op(KIND_DUMP, 5'($urandom), random_word());
          else if (pick < 95)
            send_op($urandom_range(0, 1) ? KIND_INSERT : KIND_REMOVE, 5'($urandom),
                    random_word());
          else
            send_op($urandom_range(0, 1) ? KIND_UNUSED_6 : KIND_UNUSED_7, 5'($urandom),
                    $urandom);
        end
      end else begin
        wait_for_drain();
      end
    end

    wait_for_drain();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/ila_pkg.sv
hdl/ila_cell.sv
hdl/indexed_list_insert_remove.sv
hdl/ila_checker.sv
bench/tb_indexed_list_insert_remove.sv
